/* rtl/lhp_pkg.sv */
// ----------------------------------------------------------------------------
// lhp_pkg
// Shared types, widths and codes of the latency histogram block.
// ----------------------------------------------------------------------------
package lhp_pkg;

  // histogram geometry
  localparam int BUCKETS = 8;
  localparam int BIDX_W  = $clog2(BUCKETS);
  localparam int NREGS   = 8;
  localparam int REG_IW  = $clog2(NREGS);
  localparam int CFG_AW  = REG_IW + 2;

  // field widths
  localparam int LAT_W      = 32;
  localparam int CNT_W      = 32;
  localparam int SUM_W      = 48;
  localparam int IDX_W      = 3;
  localparam int CMD_W      = 2;
  localparam int IN_TDATA_W = 40;
  localparam int CUM_W      = CNT_W + BIDX_W;
  localparam int C100_W     = CUM_W + 7;
  localparam int TGT_W      = CNT_W + 7;

  typedef logic [BIDX_W-1:0]           bidx_t;
  typedef logic [CNT_W-1:0]            cnt_t;
  typedef logic [SUM_W-1:0]            sum_t;
  typedef logic [CUM_W-1:0]            cum_t;
  typedef logic [C100_W-1:0]           c100_t;
  typedef logic [TGT_W-1:0]            tgt_t;
  typedef logic [SUM_W:0]              sum_ext_t;
  typedef logic [NREGS-1:0][LAT_W-1:0] bound_arr_t;
  typedef logic [CMD_W-1:0]            cmd_t;

  localparam bidx_t LAST_B = bidx_t'(BUCKETS - 1);
  localparam cnt_t  CNT_MAX = '1;
  localparam sum_t  SUM_MAX = '1;

  // command codes carried on in_tuser
  localparam cmd_t CMD_RECORD = 2'd0;
  localparam cmd_t CMD_REPORT = 2'd1;
  localparam cmd_t CMD_READ   = 2'd2;

  // bucket bounds after reset, bound_0 in the lowest word
  localparam bound_arr_t BOUND_RST = {
    32'd1000000, 32'd100000, 32'd50000, 32'd10000,
    32'd5000,    32'd1000,   32'd500,   32'd100
  };

  // running statistics
  typedef struct packed {
    cnt_t peak;
    sum_t sum;
    cnt_t cnt;
  } stats_t;

  // result word, last field in the lowest bits
  typedef struct packed {
    cnt_t cumulative_count;
    cnt_t p99_bound;
    cnt_t p95_bound;
    cnt_t median_bound;
    cnt_t latency_peak;
    sum_t latency_sum;
    cnt_t sample_total;
  } res_t;

  localparam int OUT_TDATA_W = $bits(res_t);

  // bucket counter write port
  typedef struct packed {
    logic  we;
    bidx_t addr;
    cnt_t  data;
  } ram_wr_t;

  // walker status toward the top level
  typedef struct packed {
    logic busy;
    logic rd_en;
    logic res_vld;
  } walk_ctl_t;

  typedef enum logic [1:0] {
    W_IDLE,
    W_READ,
    W_DONE
  } walk_state_t;

endpackage

/* rtl/lhp_ram.sv */
// ----------------------------------------------------------------------------
// lhp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lhp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read returns the old data on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/lhp_cfg.sv */
// ----------------------------------------------------------------------------
// lhp_cfg
// APB register file holding the bucket bounds.
// ----------------------------------------------------------------------------
module lhp_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [lhp_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready,
  output lhp_pkg::bound_arr_t        bounds
);

  lhp_pkg::bound_arr_t             bounds_r;
  logic [lhp_pkg::REG_IW-1:0]      reg_idx;
  logic                            wr_en;

  assign reg_idx = cfg_paddr[lhp_pkg::CFG_AW-1:2];
  assign wr_en   = cfg_psel && cfg_penable && cfg_pwrite;

  // bound registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bounds_r <= lhp_pkg::BOUND_RST;
    end else if (wr_en) begin
      bounds_r[reg_idx] <= cfg_pwdata;
    end
  end

  assign cfg_prdata = bounds_r[reg_idx];
  assign cfg_pready = 1'b1;
  assign bounds     = bounds_r;

endmodule

/* rtl/lhp_rec.sv */
// ----------------------------------------------------------------------------
// lhp_rec
// Sample update path: bucket search, counter read-modify-write and the
// running count, sum and maximum.
// ----------------------------------------------------------------------------
module lhp_rec (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rec_go,
  input  logic [lhp_pkg::LAT_W-1:0]   lat,
  input  lhp_pkg::bound_arr_t         bounds,
  input  lhp_pkg::cnt_t               rdata,
  output lhp_pkg::bidx_t              hit,
  output lhp_pkg::ram_wr_t            wr,
  output logic [lhp_pkg::BUCKETS-1:0] ent_vld,
  output lhp_pkg::stats_t             stats
);

  lhp_pkg::bidx_t              hit_c;
  logic                        s1_vld_r;
  lhp_pkg::bidx_t              s1_addr_r;
  logic                        s1_ev_r;
  logic                        fwd_vld_r;
  lhp_pkg::bidx_t              fwd_addr_r;
  lhp_pkg::cnt_t               fwd_data_r;
  logic [lhp_pkg::BUCKETS-1:0] ent_vld_r;
  lhp_pkg::cnt_t               old_c;
  lhp_pkg::cnt_t               inc_c;
  lhp_pkg::stats_t             stats_r;
  lhp_pkg::stats_t             stats_nxt;
  lhp_pkg::sum_ext_t           sum_add;

  // first bucket whose bound covers the sample, else the last one
  always_comb begin
    hit_c = lhp_pkg::LAST_B;
    for (int k = lhp_pkg::BUCKETS - 1; k >= 0; k--) begin
      if (lat <= bounds[k]) begin
        hit_c = lhp_pkg::bidx_t'(k);
      end
    end
  end

  assign hit = hit_c;

  // old counter value: forward the write of the previous cycle
  always_comb begin
    if (fwd_vld_r && (fwd_addr_r == s1_addr_r)) begin
      old_c = fwd_data_r;
    end else if (s1_ev_r) begin
      old_c = rdata;
    end else begin
      old_c = '0;
    end
    inc_c = (old_c == lhp_pkg::CNT_MAX) ? old_c : old_c + lhp_pkg::cnt_t'(1);
  end

  assign wr.we   = s1_vld_r;
  assign wr.addr = s1_addr_r;
  assign wr.data = inc_c;

  // saturating count and sum, running maximum
  always_comb begin
    stats_nxt = stats_r;
    sum_add   = lhp_pkg::sum_ext_t'(stats_r.sum) + lhp_pkg::sum_ext_t'(lat);
    if (stats_r.cnt != lhp_pkg::CNT_MAX) begin
      stats_nxt.cnt = stats_r.cnt + lhp_pkg::cnt_t'(1);
    end
    stats_nxt.sum = sum_add[lhp_pkg::SUM_W] ? lhp_pkg::SUM_MAX
                                             : sum_add[lhp_pkg::SUM_W-1:0];
    if (lat > stats_r.peak) begin
      stats_nxt.peak = lat;
    end
  end

  // control and statistics registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      fwd_vld_r <= 1'b0;
      ent_vld_r <= '0;
      stats_r   <= '0;
    end else begin
      s1_vld_r  <= rec_go;
      fwd_vld_r <= s1_vld_r;
      if (s1_vld_r) begin
        ent_vld_r[s1_addr_r] <= 1'b1;
      end
      if (rec_go) begin
        stats_r <= stats_nxt;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    s1_addr_r  <= hit_c;
    s1_ev_r    <= ent_vld_r[hit_c];
    fwd_addr_r <= s1_addr_r;
    fwd_data_r <= inc_c;
  end

  assign ent_vld = ent_vld_r;
  assign stats   = stats_r;

`ifndef SYNTHESIS
  a_ent_marked: assert property (@(posedge clk) disable iff (!rst_n)
    wr.we |=> ent_vld_r[$past(wr.addr)])
    else $error("bucket written but not marked valid");

  a_cnt_mono: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (stats_r.cnt >= $past(stats_r.cnt)))
    else $error("sample count went down");
`endif

endmodule

/* rtl/lhp_walk.sv */
// ----------------------------------------------------------------------------
// lhp_walk
// Bucket walker: reads the counters in order, accumulates the cumulative
// count and resolves percentiles or a cumulative bucket read.
// ----------------------------------------------------------------------------
module lhp_walk (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        is_read,
  input  logic [lhp_pkg::IDX_W-1:0]   idx,
  input  lhp_pkg::stats_t             stats,
  input  lhp_pkg::bound_arr_t         bounds,
  input  logic [lhp_pkg::BUCKETS-1:0] ent_vld,
  input  lhp_pkg::cnt_t               rdata,
  input  logic                        out_free,
  output lhp_pkg::walk_ctl_t          ctl,
  output lhp_pkg::bidx_t              raddr,
  output lhp_pkg::res_t               res
);

  lhp_pkg::walk_state_t state_r;
  lhp_pkg::walk_state_t state_nxt;
  lhp_pkg::bidx_t       k_r;
  logic                 iss_on_r;
  logic                 p1_vld_r;
  lhp_pkg::bidx_t       p1_k_r;
  logic                 p1_ev_r;
  logic                 p2_vld_r;
  lhp_pkg::bidx_t       p2_k_r;
  lhp_pkg::cum_t        cum_r;
  lhp_pkg::c100_t       c100_r;
  lhp_pkg::stats_t      snap_r;
  logic                 rd_mode_r;
  lhp_pkg::bidx_t       idx_r;
  lhp_pkg::bidx_t       idx_sat;
  lhp_pkg::cnt_t        t50_r;
  lhp_pkg::tgt_t        n95_r;
  lhp_pkg::tgt_t        n99_r;
  logic [2:0]           fnd_r;
  logic [2:0][31:0]     bnd_r;
  lhp_pkg::cnt_t        cap_r;
  lhp_pkg::cnt_t        data_c;
  lhp_pkg::cnt_t        bnd_k;
  logic [2:0]           reach;

  // bucket index past the last bucket reads the total
  always_comb begin
    if (idx > lhp_pkg::IDX_W'(lhp_pkg::BUCKETS - 1)) begin
      idx_sat = lhp_pkg::LAST_B;
    end else begin
      idx_sat = idx[lhp_pkg::BIDX_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lhp_pkg::W_IDLE: begin
        if (start) state_nxt = lhp_pkg::W_READ;
      end
      lhp_pkg::W_READ: begin
        if (p2_vld_r && (p2_k_r == lhp_pkg::LAST_B)) state_nxt = lhp_pkg::W_DONE;
      end
      lhp_pkg::W_DONE: begin
        if (out_free) state_nxt = lhp_pkg::W_IDLE;
      end
      default: state_nxt = lhp_pkg::W_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    ctl = '0;
    unique case (state_r)
      lhp_pkg::W_IDLE: ctl.busy = 1'b0;
      lhp_pkg::W_READ: begin
        ctl.busy  = 1'b1;
        ctl.rd_en = iss_on_r;
      end
      lhp_pkg::W_DONE: begin
        ctl.busy    = 1'b1;
        ctl.res_vld = out_free;
      end
      default: ctl = '0;
    endcase
  end

  assign raddr  = k_r;
  assign data_c = p1_ev_r ? rdata : '0;
  assign bnd_k  = bounds[p2_k_r];

  // targets met by the cumulative count through bucket p2_k_r
  always_comb begin
    reach[0] = cum_r >= lhp_pkg::cum_t'(t50_r);
    reach[1] = c100_r >= lhp_pkg::c100_t'(n95_r);
    reach[2] = c100_r >= lhp_pkg::c100_t'(n99_r);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= lhp_pkg::W_IDLE;
      iss_on_r <= 1'b0;
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      p1_vld_r <= ctl.rd_en;
      p2_vld_r <= p1_vld_r;
      if (start) begin
        iss_on_r <= 1'b1;
      end else if (ctl.rd_en && (k_r == lhp_pkg::LAST_B)) begin
        iss_on_r <= 1'b0;
      end
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    p1_k_r  <= k_r;
    p1_ev_r <= ent_vld[k_r];
    p2_k_r  <= p1_k_r;
    if (start) begin
      k_r       <= '0;
      cum_r     <= '0;
      c100_r    <= '0;
      fnd_r     <= '0;
      snap_r    <= stats;
      rd_mode_r <= is_read;
      idx_r     <= idx_sat;
      t50_r     <= (stats.cnt >> 1) + lhp_pkg::cnt_t'(stats.cnt[0]);
      n95_r     <= lhp_pkg::tgt_t'(stats.cnt) * lhp_pkg::tgt_t'(95);
      n99_r     <= lhp_pkg::tgt_t'(stats.cnt) * lhp_pkg::tgt_t'(99);
    end else begin
      if (ctl.rd_en) begin
        k_r <= k_r + lhp_pkg::bidx_t'(1);
      end
      // accumulate plain and scaled by 100
      if (p1_vld_r) begin
        cum_r  <= cum_r + lhp_pkg::cum_t'(data_c);
        c100_r <= c100_r + lhp_pkg::c100_t'(data_c) * lhp_pkg::c100_t'(100);
      end
      // first bucket reaching each target, last bucket as fallback
      if (p2_vld_r) begin
        for (int i = 0; i < 3; i++) begin
          if (!fnd_r[i] && (reach[i] || (p2_k_r == lhp_pkg::LAST_B))) begin
            fnd_r[i] <= 1'b1;
            bnd_r[i] <= bnd_k;
          end
        end
        if (p2_k_r == idx_r) begin
          cap_r <= (cum_r > lhp_pkg::cum_t'(lhp_pkg::CNT_MAX)) ? lhp_pkg::CNT_MAX
                                                               : cum_r[lhp_pkg::CNT_W-1:0];
        end
      end
    end
  end

  // result word
  always_comb begin
    res = '0;
    if (rd_mode_r) begin
      res.cumulative_count = cap_r;
    end else begin
      res.sample_total = snap_r.cnt;
      res.latency_sum  = snap_r.sum;
      res.latency_peak = snap_r.peak;
      if (snap_r.cnt != '0) begin
        res.median_bound = bnd_r[0];
        res.p95_bound    = bnd_r[1];
        res.p99_bound    = bnd_r[2];
      end
    end
  end

`ifndef SYNTHESIS
  a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lhp_pkg::W_DONE) |-> (!p1_vld_r && !p2_vld_r && !iss_on_r))
    else $error("walk finished with reads in flight");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (state_r == lhp_pkg::W_IDLE))
    else $error("walk started while busy");
`endif

endmodule

/* rtl/latency_histogram_percentiles.sv */
// ----------------------------------------------------------------------------
// latency_histogram_percentiles
// Bucketed latency histogram with count, sum, maximum and percentiles.
// ----------------------------------------------------------------------------
// Input words carry a command on in_tuser: record a sample, report the
// summary, or read the cumulative count of buckets 0 to bucket_index.
// Record words are taken one per cycle while no walk is in progress; each
// bumps count, sum and maximum and increments its bucket counter in RAM
// with a registered read-modify-write, with forwarding for back-to-back
// hits on one bucket. A report or read walks the bucket RAM one entry per
// cycle; in_tready stays low during the walk and until its result word is
// loaded into the output register. Results leave through it; while it is
// stalled and no walk is pending, records are still taken, and a finished
// walk waits until the register drains. Unknown commands are taken and
// dropped. Bucket bounds sit in APB registers at byte address 4*i, to be
// written only while the block is idle; the block does not enforce this.
// Synchronous reset restores the bounds and clears all counters at once
// (bucket entries through per-entry valid bits); no clearing pass.
// ----------------------------------------------------------------------------
module latency_histogram_percentiles (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // latency_us [31:0], bucket_index [34:32], zero fill
  input  logic [lhp_pkg::IN_TDATA_W-1:0]  in_tdata,
  // cmd [1:0]
  input  logic [lhp_pkg::CMD_W-1:0]       in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // sample_total [31:0], latency_sum [79:32], latency_peak [111:80],
  // median_bound [143:112], p95_bound [175:144], p99_bound [207:176],
  // cumulative_count [239:208]
  output logic [lhp_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [lhp_pkg::CFG_AW-1:0]      cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);

  lhp_pkg::bound_arr_t             bounds;
  logic                            in_acc;
  logic                            rec_go;
  logic                            walk_go;
  logic                            is_read;
  lhp_pkg::bidx_t                  rec_hit;
  lhp_pkg::bidx_t                  walk_raddr;
  lhp_pkg::bidx_t                  raddr;
  lhp_pkg::ram_wr_t                wr;
  lhp_pkg::cnt_t                   rdata;
  logic [lhp_pkg::BUCKETS-1:0]     ent_vld;
  lhp_pkg::stats_t                 stats;
  lhp_pkg::walk_ctl_t              wctl;
  lhp_pkg::res_t                   res;
  logic                            out_free;
  logic                            out_tvalid_r;
  lhp_pkg::res_t                   out_tdata_r;

  // command decode
  assign in_tready = !wctl.busy;
  assign in_acc    = in_tvalid && in_tready;
  assign rec_go    = in_acc && (in_tuser == lhp_pkg::CMD_RECORD);
  assign is_read   = (in_tuser == lhp_pkg::CMD_READ);
  assign walk_go   = in_acc && ((in_tuser == lhp_pkg::CMD_REPORT) || is_read);

  lhp_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .bounds      (bounds)
  );

  lhp_rec u_rec (
    .clk     (clk),
    .rst_n   (rst_n),
    .rec_go  (rec_go),
    .lat     (in_tdata[lhp_pkg::LAT_W-1:0]),
    .bounds  (bounds),
    .rdata   (rdata),
    .hit     (rec_hit),
    .wr      (wr),
    .ent_vld (ent_vld),
    .stats   (stats)
  );

  // read port goes to the walker while it is reading
  assign raddr = wctl.rd_en ? walk_raddr : rec_hit;

  lhp_ram #(
    .WIDTH (lhp_pkg::CNT_W),
    .DEPTH (lhp_pkg::BUCKETS)
  ) u_ram (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (raddr),
    .rdata (rdata)
  );

  lhp_walk u_walk (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (walk_go),
    .is_read  (is_read),
    .idx      (in_tdata[lhp_pkg::LAT_W +: lhp_pkg::IDX_W]),
    .stats    (stats),
    .bounds   (bounds),
    .ent_vld  (ent_vld),
    .rdata    (rdata),
    .out_free (out_free),
    .ctl      (wctl),
    .raddr    (walk_raddr),
    .res      (res)
  );

  // output register
  assign out_free = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (wctl.res_vld) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wctl.res_vld) begin
      out_tdata_r <= res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef SYNTHESIS
  a_no_wr_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr.we && wctl.rd_en))
    else $error("bucket write overlaps walker read");

  a_res_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    wctl.res_vld |-> (!out_tvalid_r || out_tready))
    else $error("result loaded over a pending word");
`endif

endmodule
